>>> design/assert_macros.svh
// Assertion helpers used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define MRT_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is high.
`define MRT_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> design/mrt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrt_pkg
// Types, constants and helpers for the matrix rotate / transpose block.
// ----------------------------------------------------------------------------
package mrt_pkg;

  localparam int DATA_W          = 32;
  localparam int DIM_CFG_W       = 4;
  localparam int CFG_DATA_W      = 4;
  localparam int CFG_IDX_W       = 2;
  localparam int DEFAULT_MAX_DIM = 8;
  localparam int JOB_Q_DEPTH     = 2;

  typedef enum logic [1:0] {
    MODE_CW        = 2'd0,
    MODE_CCW       = 2'd1,
    MODE_TRANSPOSE = 2'd2,
    MODE_ANTI_DIAG = 2'd3
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE   = 2'd0,
    REG_WIDTH  = 2'd1,
    REG_HEIGHT = 2'd2
  } reg_idx_t;

  // One completed source matrix waiting to be read out.
  typedef struct packed {
    mode_t                mode;
    logic [DIM_CFG_W-1:0] w;
    logic [DIM_CFG_W-1:0] h;
  } job_t;

  // Back-end status seen by the front end.
  typedef struct packed {
    logic job_pending;
    logic active;
  } back_status_t;

  // Zero acts as one, anything above the maximum acts as the maximum.
  function automatic logic [DIM_CFG_W-1:0] clamp_dim(input logic [DIM_CFG_W-1:0] d,
                                                     input int max_dim);
    logic [DIM_CFG_W-1:0] res;
    res = d;
    if (d == '0) begin
      res = DIM_CFG_W'(1);
    end else if (int'(d) > max_dim) begin
      res = DIM_CFG_W'(max_dim);
    end
    return res;
  endfunction

endpackage

>>> design/mrt_job_q.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrt_job_q
// Short queue of completed-matrix descriptors between front and back end.
// ----------------------------------------------------------------------------
module mrt_job_q import mrt_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output logic not_empty,
  output job_t head
);

  localparam int PtrW = (JOB_Q_DEPTH > 1) ? $clog2(JOB_Q_DEPTH) : 1;
  localparam int CntW = $clog2(JOB_Q_DEPTH + 1);

  job_t            entries [JOB_Q_DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic            do_push;
  logic            do_pop;

  assign do_push   = push && (count != CntW'(JOB_Q_DEPTH));
  assign do_pop    = pop && (count != '0);
  assign not_empty = (count != '0);
  assign head      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PtrW'(JOB_Q_DEPTH - 1)) ? '0 : PtrW'(wr_ptr + 1'b1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrW'(JOB_Q_DEPTH - 1)) ? '0 : PtrW'(rd_ptr + 1'b1);
      end
      if (do_push && !do_pop) begin
        count <= CntW'(count + 1'b1);
      end else if (do_pop && !do_push) begin
        count <= CntW'(count - 1'b1);
      end
    end
  end

endmodule

>>> design/mrt_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrt_front
// Holds configuration, loads source elements into the store and detects
// the element that completes a matrix.
// ----------------------------------------------------------------------------
module mrt_front import mrt_pkg::*; #(
  parameter int MaxDim = DEFAULT_MAX_DIM,
  localparam int Depth = MaxDim * MaxDim,
  localparam int AW    = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  write_enable,
  input  logic [CFG_IDX_W-1:0]  write_index,
  input  logic [CFG_DATA_W-1:0] write_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic signed [DATA_W-1:0] element,
  input  back_status_t          back_st,
  output logic                  push,
  output job_t                  push_job,
  output logic                  wr_en,
  output logic [AW-1:0]         wr_addr,
  output logic [DATA_W-1:0]     wr_data
);

  localparam int CW = $clog2(Depth + 1);

  mode_t                mode;
  logic [DIM_CFG_W-1:0] width;
  logic [DIM_CFG_W-1:0] height;
  logic [CW-1:0]        count;
  logic [CW-1:0]        count_inc;
  logic [CW-1:0]        total;
  logic [DIM_CFG_W-1:0] w_eff;
  logic [DIM_CFG_W-1:0] h_eff;
  logic                 accept;
  logic                 done;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= MODE_CW;
      width  <= DIM_CFG_W'(8);
      height <= DIM_CFG_W'(8);
    end else if (write_enable) begin
      unique case (reg_idx_t'(write_index))
        REG_MODE:   mode   <= mode_t'(write_data[1:0]);
        REG_WIDTH:  width  <= write_data;
        REG_HEIGHT: height <= write_data;
        default: ;
      endcase
    end
  end

  assign w_eff     = clamp_dim(width, MaxDim);
  assign h_eff     = clamp_dim(height, MaxDim);
  assign total     = CW'(CW'(w_eff) * CW'(h_eff));
  assign count_inc = CW'(count + 1'b1);
  assign done      = (count_inc >= total);

  // Hold input while a matrix is queued or being read out of the store.
  assign in_stall = back_st.job_pending || back_st.active;
  assign accept   = in_valid && !in_stall;

  assign wr_en   = accept;
  assign wr_addr = count[AW-1:0];
  assign wr_data = element;

  assign push          = accept && done;
  assign push_job.mode = mode;
  assign push_job.w    = w_eff;
  assign push_job.h    = h_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (accept) begin
      count <= done ? '0 : count_inc;
    end
  end

endmodule

>>> design/mrt_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrt_back
// Element store plus readout sequencer: walks the destination matrix in
// row-major order, reads the matching source entry and drives the output.
// ----------------------------------------------------------------------------
module mrt_back import mrt_pkg::*; #(
  parameter int MaxDim = DEFAULT_MAX_DIM,
  localparam int Depth = MaxDim * MaxDim,
  localparam int AW    = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     wr_en,
  input  logic [AW-1:0]            wr_addr,
  input  logic [DATA_W-1:0]        wr_data,
  input  logic                     job_valid,
  input  job_t                     job,
  output logic                     job_pop,
  output logic                     active,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [DATA_W-1:0] value,
  output logic                     final_res
);

  localparam int DimW = $clog2(MaxDim + 1);
  localparam int IW   = (MaxDim > 1) ? $clog2(MaxDim) : 1;

  logic [DATA_W-1:0] mem [Depth];

  mode_t             cur_mode;
  logic [DimW-1:0]   cur_w;
  logic [DimW-1:0]   cur_h;
  logic [IW-1:0]     i;
  logic [IW-1:0]     j;
  logic              last_i;
  logic              last_j;
  logic              last;
  logic [DimW-1:0]   r;
  logic [DimW-1:0]   c;
  logic [AW-1:0]     rd_addr;
  logic              issue;
  logic              rd_valid;
  logic [DATA_W-1:0] rd_data;
  logic              rd_final;
  logic              out_free;
  logic              rd_move;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  assign last_i = (DimW'(i) == DimW'(cur_w - 1'b1));
  assign last_j = (DimW'(j) == DimW'(cur_h - 1'b1));
  assign last   = last_i && last_j;

  // Destination (i, j) takes source (r, c).
  always_comb begin
    unique case (cur_mode)
      MODE_CW: begin
        r = DimW'(cur_h - 1'b1 - DimW'(j));
        c = DimW'(i);
      end
      MODE_CCW: begin
        r = DimW'(j);
        c = DimW'(cur_w - 1'b1 - DimW'(i));
      end
      MODE_TRANSPOSE: begin
        r = DimW'(j);
        c = DimW'(i);
      end
      default: begin
        r = DimW'(cur_h - 1'b1 - DimW'(j));
        c = DimW'(cur_w - 1'b1 - DimW'(i));
      end
    endcase
  end

  assign rd_addr = AW'(AW'(r) * AW'(cur_w) + AW'(c));

  assign out_free = !out_valid || !out_stall;
  assign rd_move  = rd_valid && out_free;
  assign issue    = active && (!rd_valid || rd_move);
  assign job_pop  = !active && job_valid;

  always_ff @(posedge clk) begin
    if (job_pop) begin
      cur_mode <= job.mode;
      cur_w    <= DimW'(job.w);
      cur_h    <= DimW'(job.h);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      i      <= '0;
      j      <= '0;
    end else if (job_pop) begin
      active <= 1'b1;
      i      <= '0;
      j      <= '0;
    end else if (issue) begin
      if (last_j) begin
        j <= '0;
        i <= IW'(i + 1'b1);
      end else begin
        j <= IW'(j + 1'b1);
      end
      if (last) begin
        active <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rd_data  <= mem[rd_addr];
      rd_final <= last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else if (issue) begin
      rd_valid <= 1'b1;
    end else if (rd_move) begin
      rd_valid <= 1'b0;
    end
  end

  // Output register: advance when empty or taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= rd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_move) begin
      value     <= rd_data;
      final_res <= rd_final;
    end
  end

endmodule

>>> design/matrix_rotate_transpose.sv
`timescale 1ns / 1ps
// The first result reaches the output register through the job queue count, the sequencer's
// active flag and the store read register after the element that completes a matrix; the
// rest follow one per cycle while the output is not stalled. Input is held from that element
// until the last store read of the matrix. Reset: clears the load count, queue, sequencer
// and output valid; mode 0, width 8, height 8. Store contents are undefined after reset.
// ----------------------------------------------------------------------------
// matrix_rotate_transpose
// Loads a source matrix in row-major order and emits it rotated clockwise,
// counter-clockwise, transposed or reflected about the anti-diagonal.
// ----------------------------------------------------------------------------
module matrix_rotate_transpose import mrt_pkg::*; #(
  parameter int MaxDim = DEFAULT_MAX_DIM
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     write_enable,
  input  logic [CFG_IDX_W-1:0]     write_index,
  input  logic [CFG_DATA_W-1:0]    write_data,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [DATA_W-1:0] element,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [DATA_W-1:0] value,
  output logic                     final_res
);

  localparam int Depth = MaxDim * MaxDim;
  localparam int AW    = (Depth > 1) ? $clog2(Depth) : 1;

  back_status_t      back_st;
  logic              push;
  job_t              push_job;
  logic              job_valid;
  job_t              head_job;
  logic              job_pop;
  logic              back_active;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [DATA_W-1:0] wr_data;

  assign back_st.job_pending = job_valid;
  assign back_st.active      = back_active;

  mrt_front #(.MaxDim(MaxDim)) u_front (
    .clk          (clk),
    .rst          (rst),
    .write_enable (write_enable),
    .write_index  (write_index),
    .write_data   (write_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .element      (element),
    .back_st      (back_st),
    .push         (push),
    .push_job     (push_job),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .wr_data      (wr_data)
  );

  mrt_job_q u_job_q (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_job  (push_job),
    .pop       (job_pop),
    .not_empty (job_valid),
    .head      (head_job)
  );

  mrt_back #(.MaxDim(MaxDim)) u_back (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .job_valid (job_valid),
    .job       (head_job),
    .job_pop   (job_pop),
    .active    (back_active),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .value     (value),
    .final_res (final_res)
  );

endmodule

>>> design/mrt_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrt_checker
// Port-level checks for the matrix rotate / transpose block.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mrt_checker import mrt_pkg::*; (
  input logic                     clk,
  input logic                     rst,
  input logic                     write_enable,
  input logic [CFG_IDX_W-1:0]     write_index,
  input logic [CFG_DATA_W-1:0]    write_data,
  input logic                     in_valid,
  input logic                     in_stall,
  input logic signed [DATA_W-1:0] element,
  input logic                     out_valid,
  input logic                     out_stall,
  input logic signed [DATA_W-1:0] value,
  input logic                     final_res
);

  // A stalled result transaction holds its payload.
  `MRT_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(value) && $stable(final_res))

  // No result is pending right after reset.
  `MRT_ASSERT_IMPL(a_reset_idle, clk, rst, $past(rst), !out_valid)

  // A matrix end cannot be followed at once by another matrix end.
  `MRT_ASSERT_NEXT(a_final_gap, clk, rst, out_valid && !out_stall && final_res, !(out_valid && final_res))

  // After an accepted element, a stalled result that does not end its matrix leaves the input held or stays valid.
  `MRT_ASSERT_NEXT(a_stall_after_load, clk, rst, $past(in_valid && !in_stall) && out_valid && !final_res && out_stall, in_stall || out_valid)

endmodule

bind matrix_rotate_transpose mrt_checker u_mrt_checker (.*);

>>> sim/mrt_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrt_result_checker
// Watches the register port and both data channels of the matrix rotate /
// transpose block. It keeps its own copy of the source matrix and registers,
// forms the rotated or reflected matrix when a load completes, and compares
// every output transaction with the oldest expected element.
// ----------------------------------------------------------------------------
module mrt_result_checker import mrt_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     write_enable,
  input  logic [CFG_IDX_W-1:0]     write_index,
  input  logic [CFG_DATA_W-1:0]    write_data,
  input  logic                     in_valid,
  input  logic                     in_stall,
  input  logic signed [DATA_W-1:0] element,
  input  logic                     out_valid,
  input  logic                     out_stall,
  input  logic signed [DATA_W-1:0] value,
  input  logic                     final_res,
  output int                       fail_count,
  output int                       pending
);

  localparam int STORE_DEPTH = DEFAULT_MAX_DIM * DEFAULT_MAX_DIM;

  typedef struct {
    logic signed [DATA_W-1:0] value;
    logic                     final_res;
  } out_elem_t;

  logic signed [DATA_W-1:0] source_elems [STORE_DEPTH];
  int unsigned              loaded;
  mode_t                    cur_mode;
  logic [DIM_CFG_W-1:0]     cfg_width;
  logic [DIM_CFG_W-1:0]     cfg_height;
  out_elem_t                expected_elems [$];

  function automatic int unsigned fold_dim(input logic [DIM_CFG_W-1:0] d);
    if (d == '0) return 1;
    if (d > DEFAULT_MAX_DIM) return DEFAULT_MAX_DIM;
    return d;
  endfunction

  // Queue the W x H result in row-major order; the last one carries the mark.
  function automatic void emit_transformed(input int unsigned w, input int unsigned h);
    int unsigned r;
    int unsigned c;
    out_elem_t   e;
    for (int unsigned i = 0; i < w; i++) begin
      for (int unsigned j = 0; j < h; j++) begin
        case (cur_mode)
          MODE_CW: begin
            r = h - 1 - j;
            c = i;
          end
          MODE_CCW: begin
            r = j;
            c = w - 1 - i;
          end
          MODE_TRANSPOSE: begin
            r = j;
            c = i;
          end
          default: begin
            r = h - 1 - j;
            c = w - 1 - i;
          end
        endcase
        e.value     = source_elems[(r * w + c) % STORE_DEPTH];
        e.final_res = (i == w - 1) && (j == h - 1);
        expected_elems.push_back(e);
      end
    end
  endfunction

  always @(posedge clk) begin : watch
    int          errs;
    int unsigned w_eff;
    int unsigned h_eff;
    out_elem_t   want;
    errs = 0;
    if (rst) begin
      foreach (source_elems[k]) source_elems[k] = '0;
      loaded     = 0;
      cur_mode   = MODE_CW;
      cfg_width  = DIM_CFG_W'(DEFAULT_MAX_DIM);
      cfg_height = DIM_CFG_W'(DEFAULT_MAX_DIM);
      expected_elems.delete();
      fail_count <= 0;
      pending    <= 0;
    end else begin
      if (write_enable) begin
        case (write_index)
          REG_MODE:   cur_mode   = mode_t'(write_data[1:0]);
          REG_WIDTH:  cfg_width  = write_data;
          REG_HEIGHT: cfg_height = write_data;
          default: ;
        endcase
      end

      // Registers are taken as they stand at each accepted element.
      if (in_valid && !in_stall) begin
        source_elems[loaded % STORE_DEPTH] = element;
        loaded = (loaded + 1) % 128;
        w_eff  = fold_dim(cfg_width);
        h_eff  = fold_dim(cfg_height);
        if (loaded >= w_eff * h_eff) begin
          emit_transformed(w_eff, h_eff);
          loaded = 0;
        end
      end

      if (out_valid && !out_stall) begin
        if (expected_elems.size() == 0) begin
          $error("unexpected output transaction: value %0d final_res %0b", value, final_res);
          errs++;
        end else begin
          want = expected_elems.pop_front();
          if (value !== want.value) begin
            $error("value: expected %0d, got %0d", want.value, value);
            errs++;
          end
          if (final_res !== want.final_res) begin
            $error("final_res: expected %0b, got %0b", want.final_res, final_res);
            errs++;
          end
        end
      end

      fail_count <= fail_count + errs;
      pending    <= expected_elems.size();
    end
  end

endmodule

>>> sim/tb_matrix_rotate_transpose.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_matrix_rotate_transpose
// Drives matrices of many shapes in all four modes through the block, with
// random gaps on the input and random stalls on the output, and reports the
// verdict from the result checker.
// ----------------------------------------------------------------------------
module tb_matrix_rotate_transpose import mrt_pkg::*;;

  localparam int                   RANDOM_ELEMS = 140;
  localparam int                   CYCLE_LIMIT  = 200000;
  localparam int                   SETTLE       = 20;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE    = 2'd3;

  logic                     clk;
  logic                     rst          = 1'b1;
  logic                     write_enable = 1'b0;
  logic [CFG_IDX_W-1:0]     write_index  = REG_MODE;
  logic [CFG_DATA_W-1:0]    write_data   = '0;
  logic                     in_valid     = 1'b0;
  logic                     in_stall;
  logic signed [DATA_W-1:0] element      = '0;
  logic                     out_valid;
  logic                     out_stall    = 1'b0;
  logic signed [DATA_W-1:0] value;
  logic                     final_res;

  int          fail_count;
  int          pending;
  int          cycle_count = 0;
  int unsigned matrix_len;
  int unsigned random_sent = 0;
  bit          tx_quiet    = 1'b0;
  bit          rx_quiet    = 1'b0;

  matrix_rotate_transpose DUT (
    .clk          (clk),
    .rst          (rst),
    .write_enable (write_enable),
    .write_index  (write_index),
    .write_data   (write_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .element      (element),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .value        (value),
    .final_res    (final_res)
  );

  mrt_result_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .write_enable (write_enable),
    .write_index  (write_index),
    .write_data   (write_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .element      (element),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .value        (value),
    .final_res    (final_res),
    .fail_count   (fail_count),
    .pending      (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Output side: after each accepted transaction, stall for a random count.
  initial begin : result_sink
    int hold;
    hold = 0;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) hold = rx_quiet ? 0 : $urandom_range(0, 7);
      out_stall <= (hold > 0);
      if (hold > 0) hold--;
    end
  end

  function automatic int unsigned dim_in_effect(input logic [DIM_CFG_W-1:0] d);
    if (d == '0) return 1;
    if (d > DEFAULT_MAX_DIM) return DEFAULT_MAX_DIM;
    return d;
  endfunction

  function automatic logic [DIM_CFG_W-1:0] pick_dim();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return DIM_CFG_W'($urandom_range(0, 15));
    if (sel == 1) return DIM_CFG_W'(DEFAULT_MAX_DIM);
    return DIM_CFG_W'($urandom_range(1, 4));
  endfunction

  // Hold input until every expected element is out, then let the block settle.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic program_regs(input mode_t m, input logic [DIM_CFG_W-1:0] w,
                              input logic [DIM_CFG_W-1:0] h);
    wait_drained();
    write_enable <= 1'b1;
    write_index  <= REG_MODE;
    write_data   <= {2'($urandom_range(0, 3)), 2'(m)};
    @(posedge clk);
    write_index  <= REG_WIDTH;
    write_data   <= w;
    @(posedge clk);
    write_index  <= REG_HEIGHT;
    write_data   <= h;
    @(posedge clk);
    write_index  <= REG_SPARE;
    write_data   <= CFG_DATA_W'($urandom_range(0, 15));
    @(posedge clk);
    write_enable <= 1'b0;
    matrix_len = dim_in_effect(w) * dim_in_effect(h);
  endtask

  task automatic send_element(input logic [DATA_W-1:0] v);
    int gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    element  <= v;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_random(input int unsigned n);
    repeat (n) begin
      send_element($urandom);
      random_sent++;
    end
  endtask

  initial begin : stimulus
    mode_t       m;
    int unsigned part;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Clockwise 3x2 with the extreme values.
    program_regs(MODE_CW, 4'd3, 4'd2);
    send_element(32'h8000_0000);
    send_element(32'h7FFF_FFFF);
    send_element(32'h0000_0000);
    send_element(32'hFFFF_FFFF);
    send_element(32'h0000_0001);
    send_element(32'h5555_5555);

    // Zero width acts as one column.
    program_regs(MODE_CCW, 4'd0, 4'd2);
    send_element(32'hAAAA_AAAA);
    send_element(32'h8000_0001);

    program_regs(MODE_TRANSPOSE, 4'd2, 4'd2);
    send_element(32'h1234_5678);
    send_element(32'hFFFF_FFFE);
    send_element(32'h7FFF_FFFE);
    send_element(32'h0F0F_F0F0);

    // Width above the maximum clamps to eight, zero height to one.
    program_regs(MODE_ANTI_DIAG, 4'd15, 4'd0);
    for (int k = 0; k < 8; k++) send_element(32'h1111_1111 * k);

    // Shrink the matrix during a load: the next element completes it.
    program_regs(MODE_CW, 4'd2, 4'd2);
    send_element(32'hDEAD_BEEF);
    send_element(32'h8000_0000);
    send_element(32'h7FFF_FFFF);
    program_regs(MODE_ANTI_DIAG, 4'd2, 4'd1);
    send_element(32'h0000_0002);

    while (random_sent < RANDOM_ELEMS) begin
      m = mode_t'($urandom_range(0, 3));
      program_regs(m, pick_dim(), pick_dim());
      tx_quiet = ($urandom_range(0, 3) == 0);
      rx_quiet <= ($urandom_range(0, 3) == 0);
      if (matrix_len > 1 && $urandom_range(0, 4) == 0) begin
        part = $urandom_range(1, matrix_len - 1);
        send_random(part);
        m = mode_t'($urandom_range(0, 3));
        program_regs(m, pick_dim(), pick_dim());
        send_random(matrix_len > part ? matrix_len - part : 1);
      end else begin
        send_random(matrix_len);
      end
    end

    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE) @(posedge clk);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+design
design/mrt_pkg.sv
design/mrt_job_q.sv
design/mrt_front.sv
design/mrt_back.sv
design/matrix_rotate_transpose.sv
design/mrt_checker.sv
sim/mrt_result_checker.sv
sim/tb_matrix_rotate_transpose.sv
